### hdl/iplpm_pkg.sv
// ----------------------------------------------------------------------------
// iplpm_pkg
// Shared types, codes and helpers for the IPv4 longest-prefix route table.
// ----------------------------------------------------------------------------
package iplpm_pkg;

   localparam int ADDR_W  = 32;
   localparam int IFACE_W = 4;
   localparam int LEN_W   = 6;
   localparam int RIDX_W  = 4;
   localparam int SLOT_W  = 8;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NOROUTE = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   // Request token that walks down the cell row, one cell per cycle.
   typedef struct packed {
      logic                 active;
      action_type           action;
      logic [ADDR_W-1:0]    addr;
      logic [ADDR_W-1:0]    mask;
      logic [ADDR_W-1:0]    gateway;
      logic [IFACE_W-1:0]   iface;
      logic [LEN_W-1:0]     mask_len;
      logic                 hit;
      logic [LEN_W-1:0]     best_len;
      logic [SLOT_W-1:0]    best_idx;
      logic [ADDR_W-1:0]    best_gw;
      logic [IFACE_W-1:0]   best_iface;
   } token_type;

   function automatic logic [2:0] nibble_ones(input logic [3:0] v);
      logic [2:0] n;
      n = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
      return n;
   endfunction

   function automatic logic [LEN_W-1:0] ones_count(input logic [ADDR_W-1:0] v);
      logic [LEN_W-1:0] n;
      n = '0;
      for (int k = 0; k < ADDR_W / 4; k++) begin
         n = n + LEN_W'(nibble_ones(v[k*4 +: 4]));
      end
      return n;
   endfunction

endpackage

### hdl/iplpm_cell.sv
// ----------------------------------------------------------------------------
// iplpm_cell
// One route slot. Holds an entry and updates the passing request token.
// ----------------------------------------------------------------------------
module iplpm_cell
   import iplpm_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_i,
   output token_type tok_o
);

   logic                valid_ff, valid_in;
   logic [ADDR_W-1:0]   net_ff;
   logic [ADDR_W-1:0]   mask_ff;
   logic [ADDR_W-1:0]   gw_ff;
   logic [IFACE_W-1:0]  iface_ff;
   logic [LEN_W-1:0]    len_ff;
   logic                wr_en;
   token_type           tok_ff, tok_in;

   always_comb begin
      tok_in   = tok_i;
      valid_in = valid_ff;
      wr_en    = 1'b0;
      if (tok_i.active) begin
         case (tok_i.action)
            ACT_ADD: begin
               if (!valid_ff && !tok_i.hit) begin
                  wr_en           = 1'b1;
                  valid_in        = 1'b1;
                  tok_in.hit      = 1'b1;
                  tok_in.best_idx = SLOT_W'(CELL_INDEX);
               end
            end
            ACT_LOOKUP: begin
               if (valid_ff && ((tok_i.addr & mask_ff) == net_ff) &&
                   (!tok_i.hit || (len_ff > tok_i.best_len))) begin
                  tok_in.hit        = 1'b1;
                  tok_in.best_len   = len_ff;
                  tok_in.best_idx   = SLOT_W'(CELL_INDEX);
                  tok_in.best_gw    = gw_ff;
                  tok_in.best_iface = iface_ff;
               end
            end
            ACT_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         net_ff   <= tok_i.addr & tok_i.mask;
         mask_ff  <= tok_i.mask;
         gw_ff    <= tok_i.gateway;
         iface_ff <= tok_i.iface;
         len_ff   <= tok_i.mask_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

### hdl/ipv4_longest_prefix_route_table.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_route_table
// Static IPv4 route table with longest-prefix lookup, add and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_* and pulse start while busy is low; the transfer
//   happens at that edge. busy stays high until the result is out.
//   Actions: add stores a route in the lowest free slot, lookup returns the
//   longest matching prefix (lowest slot on a tie), clear empties the table.
//   Result: rsp_valid is high for one cycle with rsp_* valid; the receiver
//   cannot stall, so the result must be taken in that cycle.
//   Flow: the request token walks the row of slot cells one cell per cycle,
//   then the result is registered. A new request is not taken while one is in
//   flight; start is accepted again in the cycle rsp_valid is high.
//   Config: csr_data sets the interface reported on a miss; csr_ready is
//   always high. Write only while the block is idle.
//   Reset: all slots invalid, default interface zero, block idle.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_route_table
   import iplpm_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_action,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [ADDR_W-1:0]   req_mask,
   input  logic [ADDR_W-1:0]   req_gateway,
   input  logic [IFACE_W-1:0]  req_iface_id,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [ADDR_W-1:0]   rsp_hop_addr,
   output logic [IFACE_W-1:0]  rsp_out_iface,
   output logic [RIDX_W-1:0]   rsp_route_index,
   output logic [LEN_W-1:0]    rsp_match_len,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IFACE_W-1:0]  csr_data
);

   token_type           chain [0:TABLE_DEPTH];
   token_type           head_tok;
   token_type           last_tok;
   logic                accept;
   logic                busy_ff, busy_in;
   logic [IFACE_W-1:0]  dflt_iface_ff;
   logic                rsp_valid_ff;
   status_type          status_ff, status_in;
   logic [ADDR_W-1:0]   hop_addr_ff, hop_addr_in;
   logic [IFACE_W-1:0]  out_iface_ff, out_iface_in;
   logic [RIDX_W-1:0]   route_index_ff, route_index_in;
   logic [LEN_W-1:0]    match_len_ff, match_len_in;

   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;
   assign last_tok  = chain[TABLE_DEPTH];
   assign chain[0]  = head_tok;

   always_comb begin
      head_tok            = '0;
      head_tok.active     = accept;
      head_tok.action     = action_type'(req_action);
      head_tok.addr       = req_address;
      head_tok.mask       = req_mask;
      head_tok.gateway    = req_gateway;
      head_tok.iface      = req_iface_id;
      head_tok.mask_len   = ones_count(req_mask);
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      iplpm_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .tok_i(chain[g]),
         .tok_o(chain[g+1])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (last_tok.active) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      status_in      = ST_OK;
      hop_addr_in    = '0;
      out_iface_in   = '0;
      route_index_in = '0;
      match_len_in   = '0;
      case (last_tok.action)
         ACT_ADD: begin
            if (last_tok.hit) begin
               route_index_in = RIDX_W'(last_tok.best_idx);
            end else begin
               status_in = ST_FULL;
            end
         end
         ACT_LOOKUP: begin
            if (last_tok.hit) begin
               hop_addr_in    = (last_tok.best_gw == '0) ? last_tok.addr : last_tok.best_gw;
               out_iface_in   = last_tok.best_iface;
               route_index_in = RIDX_W'(last_tok.best_idx);
               match_len_in   = last_tok.best_len;
            end else begin
               status_in    = ST_NOROUTE;
               out_iface_in = dflt_iface_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dflt_iface_ff <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= last_tok.active;
         if (csr_valid && csr_ready) begin
            dflt_iface_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (last_tok.active) begin
         status_ff      <= status_in;
         hop_addr_ff    <= hop_addr_in;
         out_iface_ff   <= out_iface_in;
         route_index_ff <= route_index_in;
         match_len_ff   <= match_len_in;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_hop_addr    = hop_addr_ff;
   assign rsp_out_iface   = out_iface_ff;
   assign rsp_route_index = route_index_ff;
   assign rsp_match_len   = match_len_ff;

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not set after request transfer");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("result without a request in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_FULL)) |->
         ((route_index_ff == '0) && (hop_addr_ff == '0) && (match_len_ff == '0)))
      else $error("table full result carries data");

endmodule

### tb/tb_ipv4_longest_prefix_route_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_longest_prefix_route_table
// Self-checking bench for the IPv4 longest-prefix route table. A short table
// of directed requests covers the field extremes, duplicate and overlapping
// prefixes, non-contiguous masks, a full table, clear and the unused action.
// Random phases follow. Each phase sets the miss interface, then runs adds,
// lookups, clears and unused actions around a small pool of networks, so that
// prefixes nest and compete. Results match typed rows or a behavioral table model.
// ----------------------------------------------------------------------------
module tb_ipv4_longest_prefix_route_table;
   import iplpm_pkg::*;

   localparam int DEPTH      = 16;
   localparam int RAND_ITEMS = 1350;

   typedef struct {
      action_type           act;
      logic [ADDR_W-1:0]    addr;
      logic [ADDR_W-1:0]    mask;
      logic [ADDR_W-1:0]    gw;
      logic [IFACE_W-1:0]   ifc;
   } route_req_type;

   typedef struct {
      status_type           status;
      logic [ADDR_W-1:0]    hop_addr;
      logic [IFACE_W-1:0]   out_iface;
      logic [RIDX_W-1:0]    route_index;
      logic [LEN_W-1:0]     match_len;
   } route_rsp_type;

   typedef struct {
      route_req_type        req;
      logic                 known;
      route_rsp_type        rsp;
   } route_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_action;
   logic [ADDR_W-1:0]   req_address;
   logic [ADDR_W-1:0]   req_mask;
   logic [ADDR_W-1:0]   req_gateway;
   logic [IFACE_W-1:0]  req_iface_id;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [ADDR_W-1:0]   rsp_hop_addr;
   logic [IFACE_W-1:0]  rsp_out_iface;
   logic [RIDX_W-1:0]   rsp_route_index;
   logic [LEN_W-1:0]    rsp_match_len;
   logic                csr_valid;
   logic                csr_ready;
   logic [IFACE_W-1:0]  csr_data;

   // model of the table
   logic [ADDR_W-1:0]   route_net  [DEPTH];
   logic [ADDR_W-1:0]   route_mask [DEPTH];
   logic [ADDR_W-1:0]   route_gw   [DEPTH];
   logic [IFACE_W-1:0]  route_if   [DEPTH];
   logic [DEPTH-1:0]    route_used;
   int                  route_total;
   logic [IFACE_W-1:0]  miss_iface;

   route_rsp_type       route_expect_q [$];
   route_row_type       directed_rows [$];
   int                  mismatch_count;

   ipv4_longest_prefix_route_table #(
      .TABLE_DEPTH(DEPTH)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_address    (req_address),
      .req_mask       (req_mask),
      .req_gateway    (req_gateway),
      .req_iface_id   (req_iface_id),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_hop_addr   (rsp_hop_addr),
      .rsp_out_iface  (rsp_out_iface),
      .rsp_route_index(rsp_route_index),
      .rsp_match_len  (rsp_match_len),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("ipv4_longest_prefix_route_table test failed");
      $finish;
   end

   function automatic route_rsp_type route_table_apply(input route_req_type r);
      route_rsp_type       res;
      int                  best;
      logic [LEN_W-1:0]    len;
      logic [LEN_W-1:0]    best_len;
      logic                placed;
      res = '{ST_OK, '0, '0, '0, '0};
      best = -1;
      best_len = '0;
      placed = 1'b0;
      case (r.act)
         ACT_ADD: begin
            if (route_total >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (!placed && !route_used[i]) begin
                     route_net[i]  = r.addr;
                     route_mask[i] = r.mask;
                     route_gw[i]   = r.gw;
                     route_if[i]   = r.ifc;
                     route_used[i] = 1'b1;
                     route_total++;
                     res.route_index = RIDX_W'(i);
                     placed = 1'b1;
                  end
               end
            end
         end
         ACT_LOOKUP: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (route_used[i] &&
                   ((r.addr & route_mask[i]) == (route_net[i] & route_mask[i]))) begin
                  len = LEN_W'($countones(route_mask[i]));
                  if (best < 0 || len > best_len) begin
                     best = i;
                     best_len = len;
                  end
               end
            end
            if (best < 0) begin
               res.status = ST_NOROUTE;
               res.out_iface = miss_iface;
            end else begin
               res.hop_addr = (route_gw[best] == '0) ? r.addr : route_gw[best];
               res.out_iface = route_if[best];
               res.route_index = RIDX_W'(best);
               res.match_len = best_len;
            end
         end
         ACT_CLEAR: begin
            route_used = '0;
            route_total = 0;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic step_row(input action_type act, input logic [ADDR_W-1:0] a,
                           input logic [ADDR_W-1:0] m, input logic [ADDR_W-1:0] g,
                           input logic [IFACE_W-1:0] f);
      route_row_type row;
      row.req = '{act, a, m, g, f};
      row.known = 1'b0;
      row.rsp = '{ST_OK, '0, '0, '0, '0};
      directed_rows.push_back(row);
   endtask

   task automatic typed_row(input action_type act, input logic [ADDR_W-1:0] a,
                            input logic [ADDR_W-1:0] m, input logic [ADDR_W-1:0] g,
                            input logic [IFACE_W-1:0] f, input status_type st,
                            input logic [ADDR_W-1:0] hop, input logic [IFACE_W-1:0] oif,
                            input logic [RIDX_W-1:0] idx, input logic [LEN_W-1:0] plen);
      route_row_type row;
      row.req = '{act, a, m, g, f};
      row.known = 1'b1;
      row.rsp = '{st, hop, oif, idx, plen};
      directed_rows.push_back(row);
   endtask

   task automatic send_route_req(input route_req_type r, input logic known,
                                 input route_rsp_type typed_rsp, input int gap);
      route_rsp_type predicted;
      @(negedge clock);
      while (busy) @(negedge clock);
      repeat (gap) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_action   <= r.act;
      req_address  <= r.addr;
      req_mask     <= r.mask;
      req_gateway  <= r.gw;
      req_iface_id <= r.ifc;
      do @(posedge clock); while (busy);
      predicted = route_table_apply(r);
      route_expect_q.push_back(known ? typed_rsp : predicted);
   endtask

   task automatic drain_routes();
      @(negedge clock);
      start <= 1'b0;
      while (route_expect_q.size() != 0) @(posedge clock);
      repeat (2 * DEPTH) @(posedge clock);
   endtask

   task automatic write_miss_iface(input logic [IFACE_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      miss_iface = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      route_rsp_type want;
      if (!reset && rsp_valid) begin
         if (route_expect_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result: status %0d hop %h iface %0d idx %0d len %0d",
                        rsp_status, rsp_hop_addr, rsp_out_iface, rsp_route_index,
                        rsp_match_len);
            mismatch_count++;
         end else begin
            want = route_expect_q.pop_front();
            if (rsp_status !== want.status || rsp_hop_addr !== want.hop_addr ||
                rsp_out_iface !== want.out_iface || rsp_route_index !== want.route_index ||
                rsp_match_len !== want.match_len) begin
               if (mismatch_count < 10) begin
                  $display("mismatch at %0t: status %0d/%0d hop %h/%h iface %0d/%0d",
                           $realtime, rsp_status, want.status, rsp_hop_addr, want.hop_addr,
                           rsp_out_iface, want.out_iface);
                  $display("   idx %0d/%0d len %0d/%0d (actual/expected)",
                           rsp_route_index, want.route_index, rsp_match_len,
                           want.match_len);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      route_req_type       req;
      route_rsp_type       no_rsp;
      logic [ADDR_W-1:0]   pool [4];
      logic [ADDR_W-1:0]   pm;
      int                  rand_sent;
      int                  phase;
      int                  n;
      int                  sel;
      int                  k;
      logic                burst;

      reset        = 1'b1;
      start        = 1'b0;
      req_action   = '0;
      req_address  = '0;
      req_mask     = '0;
      req_gateway  = '0;
      req_iface_id = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      mismatch_count = 0;
      route_used   = '0;
      route_total  = 0;
      miss_iface   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         route_net[i]  = '0;
         route_mask[i] = '0;
         route_gw[i]   = '0;
         route_if[i]   = '0;
      end
      no_rsp = '{ST_OK, '0, '0, '0, '0};

      // directed: empty table, unused action, extremes, nesting, ties, full, clear
      typed_row(ACT_LOOKUP, 32'h0, 32'h0, 32'h0, 4'h0, ST_NOROUTE, 32'h0, 4'h0, 4'h0, 6'd0);
      typed_row(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF,
                ST_OK, 32'h0, 4'h0, 4'h0, 6'd0);
      typed_row(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF,
                ST_OK, 32'h0, 4'h0, 4'h0, 6'd0);
      typed_row(ACT_ADD, 32'h0, 32'h0, 32'h0, 4'h0, ST_OK, 32'h0, 4'h0, 4'h1, 6'd0);
      typed_row(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0,
                ST_OK, 32'hFFFF_FFFF, 4'hF, 4'h0, 6'd32);
      step_row(ACT_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 4'h3);
      step_row(ACT_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0, 4'h4);
      step_row(ACT_ADD, 32'h0A01_FFFF, 32'hFFFF_0000, 32'h0102_0304, 4'h5);
      step_row(ACT_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'h0);
      step_row(ACT_LOOKUP, 32'h0A7F_0001, 32'h0, 32'h0, 4'h0);
      step_row(ACT_ADD, 32'h5A5A_5A5A, 32'hF0F0_F0F0, 32'hC000_0001, 4'h9);
      step_row(ACT_LOOKUP, 32'h5F5F_5F5F, 32'h0, 32'h0, 4'h0);
      for (int i = 0; i < 10; i++)
         step_row(ACT_ADD, 32'hC0A8_0000 | (i << 8), 32'hFFFF_FF00,
                  (i % 2) ? 32'hC0A8_0001 : 32'h0, IFACE_W'(i));
      typed_row(ACT_ADD, 32'h1234_5678, 32'hFFFF_FFFF, 32'h1, 4'h7,
                ST_FULL, 32'h0, 4'h0, 4'h0, 6'd0);
      typed_row(ACT_CLEAR, 32'h0, 32'h0, 32'h0, 4'h0, ST_OK, 32'h0, 4'h0, 4'h0, 6'd0);
      typed_row(ACT_LOOKUP, 32'hC0A8_0301, 32'h0, 32'h0, 4'h0,
                ST_NOROUTE, 32'h0, 4'h0, 4'h0, 6'd0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_route_req(directed_rows[i].req, directed_rows[i].known,
                        directed_rows[i].rsp, $urandom_range(0, 14));

      // random phases around a small pool of networks
      rand_sent = 0;
      phase = 0;
      while (rand_sent < RAND_ITEMS) begin
         drain_routes();
         write_miss_iface((phase == 0) ? 4'hF : (phase == 1) ? 4'h0
                                               : IFACE_W'($urandom_range(0, 15)));
         for (int i = 0; i < 4; i++) pool[i] = $urandom();
         burst = ($urandom_range(0, 3) == 0);
         n = $urandom_range(20, 60);
         if ($urandom_range(0, 2) != 0) begin
            req = '{ACT_CLEAR, $urandom(), $urandom(), $urandom(), IFACE_W'($urandom())};
            send_route_req(req, 1'b0, no_rsp, burst ? 0 : $urandom_range(0, 14));
            rand_sent++;
         end
         for (int j = 0; j < n; j++) begin
            sel = $urandom_range(0, 99);
            k = $urandom_range(0, 3);
            req = '{ACT_NONE, $urandom(), $urandom(), $urandom(), IFACE_W'($urandom())};
            if (sel < 35) begin
               pm = 32'hFFFF_FFFF << (32 - $urandom_range(0, 32));
               if ($urandom_range(0, 6) == 0) pm = $urandom();
               req.act = ACT_ADD;
               req.mask = pm;
               req.addr = (pool[k] & pm) | ($urandom() & ~pm);
               if ($urandom_range(0, 2) == 0) req.gw = '0;
            end else if (sel < 85) begin
               req.act = ACT_LOOKUP;
               if ($urandom_range(0, 4) != 0) begin
                  pm = 32'hFFFF_FFFF << (32 - $urandom_range(8, 32));
                  req.addr = (pool[k] & pm) | ($urandom() & ~pm);
               end
            end else if (sel < 93) begin
               req.act = ACT_CLEAR;
            end
            send_route_req(req, 1'b0, no_rsp, burst ? 0 : $urandom_range(0, 14));
            rand_sent++;
         end
         phase++;
      end

      drain_routes();
      if (mismatch_count == 0) begin
         $display("ipv4_longest_prefix_route_table test passed");
      end else begin
         $display("ipv4_longest_prefix_route_table test failed");
      end
      $finish;
   end

endmodule

### sim.f
hdl/iplpm_pkg.sv
hdl/iplpm_cell.sv
hdl/ipv4_longest_prefix_route_table.sv
tb/tb_ipv4_longest_prefix_route_table.sv
